// ===== design/bb77_pkg.sv =====
// Shared constants, register codes and types of the 7x7 box blur unit.
package bb77_pkg;

    // Window geometry
    localparam int RADIUS       = 3;
    localparam int SPAN         = 2 * RADIUS + 1;
    localparam int LINES        = 2 * RADIUS;
    localparam int AREA         = SPAN * SPAN;

    // Raster limits and register defaults
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int HEIGHT_LIMIT  = 2048;
    localparam int CFG_W         = 12;
    localparam int ROW_W         = 12;
    localparam int WIDTH_RESET   = 1280;
    localparam int HEIGHT_RESET  = 720;

    // Pixel layout
    localparam int PIX_W        = 32;
    localparam int CH_W         = 8;
    localparam int NUM_CH       = 4;
    localparam int SLOT_W       = 3;
    localparam int WORD_W       = LINES * PIX_W;

    // Sum widths: one column of SPAN samples, then the whole window
    localparam int COL_SUM_W    = 11;
    localparam int WIN_SUM_W    = 14;

    // Divide by AREA as a multiply by a rounded-up reciprocal and a shift;
    // exact for every window sum up to AREA * 255
    localparam int RECIP        = 21400;
    localparam int RECIP_W      = 15;
    localparam int RECIP_SHIFT  = 20;

    typedef enum logic
    {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic
    {
        KIND_PIXEL = 1'b0,
        KIND_PAD   = 1'b1
    } kind_t;

    typedef logic [COL_SUM_W-1:0] col_sum_t;

    // Per-tick control handed from the position tracker down the pipeline
    typedef struct packed
    {
        logic              col_in;  // column lies inside the image
        logic              first;   // first column of a row
        logic              emit;    // tick completes a window
        logic              eof;     // window of the last image pixel
        logic [LINES-1:0]  mask;    // stored line slots that take part
        logic [SLOT_W-1:0] wslot;   // slot that takes this row's sample
    } tick_ctl_t;

endpackage

// ===== design/bb77_pos.sv =====
// Raster position tracking, configuration registers and line-slot selection.
module bb77_pos #(
    parameter int MAX_WIDTH = bb77_pkg::MAX_WIDTH_DEF,
    parameter int CNT_W     = $clog2(MAX_WIDTH + bb77_pkg::RADIUS),
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [bb77_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        accept,
    input  logic                        kind,
    input  logic [bb77_pkg::PIX_W-1:0]  pixel,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    output logic [bb77_pkg::PIX_W-1:0]  sample,
    output bb77_pkg::tick_ctl_t         ctl
);
    import bb77_pkg::*;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    logic [CFG_W:0]    w_wide;
    logic [CNT_W-1:0]  eff_w;
    logic [ROW_W-1:0]  eff_h;
    logic [CNT_W-1:0]  last_col;
    logic [ROW_W-1:0]  last_row;
    logic              col_in;
    logic              row_in;
    logic [LINES-1:0]  line_mask;

    // Clamp the configured size to the supported range
    always_comb
    begin
        if (width_reg == '0)
            w_wide = (CFG_W+1)'(1);
        else if ({1'b0, width_reg} > (CFG_W+1)'(MAX_WIDTH))
            w_wide = (CFG_W+1)'(MAX_WIDTH);
        else
            w_wide = {1'b0, width_reg};
        eff_w = CNT_W'(w_wide);

        if (height_reg == '0)
            eff_h = ROW_W'(1);
        else if (height_reg > ROW_W'(HEIGHT_LIMIT))
            eff_h = ROW_W'(HEIGHT_LIMIT);
        else
            eff_h = height_reg;
    end

    assign last_col = eff_w + CNT_W'(RADIUS - 1);
    assign last_row = eff_h + ROW_W'(RADIUS - 1);
    assign col_in   = col_reg < eff_w;
    assign row_in   = row_reg < eff_h;

    // Advance along the extended raster, wrapping at the frame end
    always_comb
    begin
        col_next  = col_reg + CNT_W'(1);
        row_next  = row_reg;
        slot_next = slot_reg;
        if (col_reg == last_col)
        begin
            col_next = '0;
            if (row_reg == last_row)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = row_reg + ROW_W'(1);
                slot_next = (slot_reg == SLOT_W'(LINES - 1)) ? '0 : slot_reg + SLOT_W'(1);
            end
        end
    end

    // Hold configuration and position; a register write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(WIDTH_RESET);
            height_reg <= CFG_W'(HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // Pick the stored lines that lie inside the window and the image
    always_comb
    begin
        logic [SLOT_W-1:0] k;
        line_mask = '0;
        for (int j = 0; j < LINES; j++)
        begin
            if (slot_reg > SLOT_W'(j))
                k = slot_reg - SLOT_W'(j);
            else
                k = slot_reg + SLOT_W'(LINES) - SLOT_W'(j);
            line_mask[j] = col_in && (row_reg >= ROW_W'(k))
                           && (row_reg < eff_h + ROW_W'(k));
        end
    end

    assign ctl.mask   = line_mask;
    assign ctl.col_in = col_in;
    assign ctl.first  = col_reg == '0;
    assign ctl.emit   = (col_reg >= CNT_W'(RADIUS)) && (row_reg >= ROW_W'(RADIUS));
    assign ctl.eof    = (col_reg == last_col) && (row_reg == last_row);
    assign ctl.wslot  = slot_reg;

    // Padding positions and padding ticks count as zero pixels
    assign sample  = (col_in && row_in && kind == KIND_PIXEL) ? pixel : '0;
    assign rd_en   = accept && col_in;
    assign rd_addr = col_reg[AW-1:0];

endmodule

// ===== design/bb77_line_store.sv =====
// Line store memory with read-modify-write and the vertical column sum.
module bb77_line_store #(
    parameter int MAX_WIDTH = bb77_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        accept,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    input  logic [bb77_pkg::PIX_W-1:0]  sample,
    input  bb77_pkg::tick_ctl_t         ctl,
    output logic                        s1_valid,
    output bb77_pkg::tick_ctl_t         s1_ctl,
    output bb77_pkg::col_sum_t          vert [bb77_pkg::NUM_CH]
);
    import bb77_pkg::*;

    // One word per column holds that column of all stored lines
    logic [WORD_W-1:0] mem [MAX_WIDTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en;

    logic              s1_valid_reg;
    tick_ctl_t         ctl_reg;
    logic [PIX_W-1:0]  sample_reg;
    logic [AW-1:0]     addr_reg;

    // Read at acceptance, write back as the tick leaves this stage.
    // One column is touched once per row, at least four ticks apart, so
    // a read never meets a pending write to the same word.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (wr_en)
            mem[addr_reg] <= wr_data;
    end

    // Hold the tick beside its read data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg    <= ctl;
            sample_reg <= sample;
            addr_reg   <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= accept;
    end

    assign wr_en = advance && s1_valid_reg && ctl_reg.col_in;

    // Replace the oldest line slot with the new sample
    always_comb
    begin
        for (int j = 0; j < LINES; j++)
        begin
            if (ctl_reg.wslot == SLOT_W'(j))
                wr_data[j*PIX_W +: PIX_W] = sample_reg;
            else
                wr_data[j*PIX_W +: PIX_W] = rd_data_reg[j*PIX_W +: PIX_W];
        end
    end

    // Sum each channel down the column
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            vert[ch] = COL_SUM_W'(sample_reg[ch*CH_W +: CH_W]);
            for (int j = 0; j < LINES; j++)
            begin
                if (ctl_reg.mask[j])
                    vert[ch] = vert[ch]
                               + COL_SUM_W'(rd_data_reg[j*PIX_W + ch*CH_W +: CH_W]);
            end
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = ctl_reg;

endmodule

// ===== design/bb77_window.sv =====
// Horizontal window of column sums, window total, divide and output register.
module bb77_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s1_valid,
    input  bb77_pkg::tick_ctl_t         s1_ctl,
    input  bb77_pkg::col_sum_t          vert [bb77_pkg::NUM_CH],
    input  logic                        m_tready,
    output logic                        advance,
    output logic                        m_tvalid,
    output logic [bb77_pkg::PIX_W-1:0]  m_tdata,
    output logic                        m_tlast
);
    import bb77_pkg::*;

    col_sum_t                 win_reg [SPAN][NUM_CH];
    logic                     e_valid_reg;
    logic                     e_eof_reg;
    logic [WIN_SUM_W-1:0]     win_sum [NUM_CH];
    logic [WIN_SUM_W-1:0]     q_sum_reg [NUM_CH];
    logic                     q_valid_reg;
    logic                     q_eof_reg;
    logic [PIX_W-1:0]         quot;
    logic [WIN_SUM_W+RECIP_W-1:0] prod [NUM_CH];
    logic                     out_valid_reg;
    logic [PIX_W-1:0]         out_data_reg;
    logic                     out_last_reg;

    // Move the pipe whenever the output slot is free or being taken
    assign advance = !out_valid_reg || m_tready;

    // Shift in the new column; the first column of a row starts clean
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid)
        begin
            for (int i = 0; i < SPAN - 1; i++)
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                    win_reg[i][ch] <= s1_ctl.first ? '0 : win_reg[i+1][ch];
            end
            for (int ch = 0; ch < NUM_CH; ch++)
                win_reg[SPAN-1][ch] <= vert[ch];
        end
    end

    // Total each channel over the window
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            win_sum[ch] = '0;
            for (int i = 0; i < SPAN; i++)
                win_sum[ch] = win_sum[ch] + WIN_SUM_W'(win_reg[i][ch]);
        end
    end

    // Divide by the window area
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            prod[ch] = (WIN_SUM_W+RECIP_W)'(q_sum_reg[ch])
                       * (WIN_SUM_W+RECIP_W)'(RECIP);
            quot[ch*CH_W +: CH_W] = prod[ch][RECIP_SHIFT +: CH_W];
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e_eof_reg    <= s1_ctl.eof;
            q_eof_reg    <= e_eof_reg;
            out_last_reg <= q_eof_reg;
            out_data_reg <= quot;
            for (int ch = 0; ch < NUM_CH; ch++)
                q_sum_reg[ch] <= win_sum[ch];
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            e_valid_reg   <= s1_valid && s1_ctl.emit;
            q_valid_reg   <= e_valid_reg;
            out_valid_reg <= q_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/box_blur_7x7_unit.sv =====
// Top level of the streaming 7x7 box blur unit.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: pixel_in; s_tuser: kind
//  m_      | out | m_tvalid/m_tready  | m_tdata: pixel_out; m_tlast: end_of_frame
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data (12 bits)
//
// One transaction per clock while m_ is not stalled; the tick that completes a window
// passes the memory read, column sum, window total and divide registers before its
// result appears on m_.
// The line store is one memory word per column read and written back once per
// tick, so its single read and single write port set the rate.
// Reset clears position and pipeline valid flags; the line store is not cleared
// and only lines written earlier in the same frame are read.
// A stalled output holds the whole pipe and drops s_tready.
module box_blur_7x7_unit #(
    parameter int MAX_WIDTH = bb77_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bb77_pkg::PIX_W-1:0]  s_tdata,   // [31:0] pixel_in
    input  logic                        s_tuser,   // [0] kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bb77_pkg::PIX_W-1:0]  m_tdata,   // [31:0] pixel_out
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [bb77_pkg::CFG_W-1:0]  cfg_data
);
    import bb77_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic             advance;
    logic             accept;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [PIX_W-1:0] sample;
    tick_ctl_t        ctl;
    logic             s1_valid;
    tick_ctl_t        s1_ctl;
    col_sum_t         vert [NUM_CH];

    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    bb77_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .kind      (s_tuser),
        .pixel     (s_tdata),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .sample    (sample),
        .ctl       (ctl)
    );

    bb77_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .accept   (accept),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .sample   (sample),
        .ctl      (ctl),
        .s1_valid (s1_valid),
        .s1_ctl   (s1_ctl),
        .vert     (vert)
    );

    bb77_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_ctl   (s1_ctl),
        .vert     (vert),
        .m_tready (m_tready),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/bb77_checker.sv =====
// Port-level checks of the box blur unit and their binding.
module bb77_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // Input stalls only behind a full, blocked output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    a_free_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind box_blur_7x7_unit bb77_checker u_bb77_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
